// ===== rtl/lmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local minimum counter package
// Shared constants and the per-stage control type of the minimum counter.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int CFG_WIDTH_BITS = 11;
    localparam int COUNT_BITS     = 16;
    localparam int MIN_FRAME_WIDTH = 3;
    localparam logic [CFG_WIDTH_BITS-1:0] FRAME_WIDTH_RESET = 11'd10;

    // Row position only needs to know whether two full rows have gone by.
    localparam int ROW_BITS = 2;
    localparam logic [ROW_BITS-1:0] ROW_TESTABLE = 2'd2;

    // Neighbor cells of the compare window.
    localparam int NUM_NEIGHBOURS = 4;
    localparam int NB_UP    = 0;
    localparam int NB_DOWN  = 1;
    localparam int NB_LEFT  = 2;
    localparam int NB_RIGHT = 3;

    // Result buffer.
    localparam int RESULT_DEPTH    = 4;
    localparam int RESULT_PTR_BITS = 2;
    localparam int RESULT_CNT_BITS = 3;

    typedef struct packed {
        logic valid;
        logic test;
        logic last;
    } stage_ctl_t;

endpackage

// ===== rtl/local_minimum_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local minimum counter
// Counts interior pixels of a frame that are below all four direct neighbors.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock in row-major order while in_ready is
// high, with no gaps needed between rows or frames. Each pixel transfer
// reads the two line stores; in the s1 stage the line stores are written
// and the four neighbor cells loaded, and in the s2 stage the window is
// compared and counted; the last pixel's s2 stage pushes the frame count.
// Results wait in a four-entry buffer; input is held off only while that
// buffer, together with frame ends still in the pipeline, is full. The line
// stores need no clearing after reset, so the block is ready at once.
// frame_width is clamped to 3..MAX_WIDTH and should be written between frames.
// ----------------------------------------------------------------------------
module local_minimum_counter_unit
    import lmc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_WIDTH_BITS-1:0] cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PIXEL_BITS-1:0]     pixel_value,
    input  logic                      frame_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COUNT_BITS-1:0]     minima_count
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WID_BITS = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_BITS) ?
                              $clog2(MAX_WIDTH + 1) : CFG_WIDTH_BITS;
    localparam logic [WID_BITS-1:0] MAX_W = WID_BITS'(MAX_WIDTH);
    localparam logic [WID_BITS-1:0] MIN_W = WID_BITS'(MIN_FRAME_WIDTH);
    localparam logic [WID_BITS-1:0] ONE_W = WID_BITS'(1);

    logic [CFG_WIDTH_BITS-1:0] frame_width_reg;
    logic [COL_BITS-1:0]       column_reg, column_next;
    logic [ROW_BITS-1:0]       row_reg, row_next;
    logic [COUNT_BITS-1:0]     total_reg, total_next;

    logic [WID_BITS-1:0] width_cfg, width_eff, col_cur;
    logic [COL_BITS-1:0] col_idx, col_plus;
    logic                last_col, test_now, accept;

    stage_ctl_t            s1_ctl_reg, s2_ctl_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [PIXEL_BITS-1:0] centre_reg;

    logic [COL_BITS-1:0]   ra_addr [2];
    logic [PIXEL_BITS-1:0] ra_data [2];
    logic [COL_BITS-1:0]   rt_addr [1];
    logic [PIXEL_BITS-1:0] rt_data [1];

    logic [PIXEL_BITS-1:0]     nb_in [NUM_NEIGHBOURS];
    logic [NUM_NEIGHBOURS-1:0] nb_below;
    logic                      hit;

    logic [COUNT_BITS-1:0]      result_mem [RESULT_DEPTH];
    logic [RESULT_PTR_BITS-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [RESULT_CNT_BITS-1:0] result_cnt_reg, pending;
    logic                       push, pop;

    // ------------------------------------------------------------------------
    // Column and row tracking
    // ------------------------------------------------------------------------
    always_comb
    begin
        width_cfg = WID_BITS'(frame_width_reg);
        if (width_cfg < MIN_W)
        begin
            width_eff = MIN_W;
        end
        else if (width_cfg > MAX_W)
        begin
            width_eff = MAX_W;
        end
        else
        begin
            width_eff = width_cfg;
        end

        // After a width change the row may end early at the new last column.
        if (WID_BITS'(column_reg) >= width_eff)
        begin
            col_cur = width_eff - ONE_W;
        end
        else
        begin
            col_cur = WID_BITS'(column_reg);
        end

        col_idx  = col_cur[COL_BITS-1:0];
        col_plus = col_idx + COL_BITS'(1);
        last_col = (col_cur == (width_eff - ONE_W));
        test_now = (row_reg == ROW_TESTABLE) && (col_cur != '0) &&
                   (col_cur < (width_eff - ONE_W));

        column_next = column_reg;
        row_next    = row_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                column_next = '0;
                row_next    = '0;
            end
            else if (last_col)
            begin
                column_next = '0;
                if (row_reg != ROW_TESTABLE)
                begin
                    row_next = row_reg + ROW_BITS'(1);
                end
            end
            else
            begin
                column_next = col_plus;
            end
        end
    end

    assign accept = in_valid && in_ready;

    // ------------------------------------------------------------------------
    // Line stores: the row above is read at this column and the next one,
    // the row two above at this column.
    // ------------------------------------------------------------------------
    assign ra_addr[0] = col_idx;
    assign ra_addr[1] = col_plus;
    assign rt_addr[0] = col_idx;

    lmc_line_store #(
        .DEPTH      (MAX_WIDTH),
        .DATA_BITS  (PIXEL_BITS),
        .READ_PORTS (2)
    ) u_row_above (
        .clk     (clk),
        .wr_en   (s1_ctl_reg.valid),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (accept),
        .rd_addr (ra_addr),
        .rd_data (ra_data)
    );

    // The row two above takes over what the row above held at this column.
    lmc_line_store #(
        .DEPTH      (MAX_WIDTH),
        .DATA_BITS  (PIXEL_BITS),
        .READ_PORTS (1)
    ) u_row_two_above (
        .clk     (clk),
        .wr_en   (s1_ctl_reg.valid),
        .wr_addr (s1_col_reg),
        .wr_data (ra_data[0]),
        .rd_en   (accept),
        .rd_addr (rt_addr),
        .rd_data (rt_data)
    );

    // ------------------------------------------------------------------------
    // Neighbor window. The left neighbor is the center of the previous
    // pixel, handed along from the center register.
    // ------------------------------------------------------------------------
    assign nb_in[NB_UP]    = rt_data[0];
    assign nb_in[NB_DOWN]  = s1_pixel_reg;
    assign nb_in[NB_LEFT]  = centre_reg;
    assign nb_in[NB_RIGHT] = ra_data[1];

    for (genvar g = 0; g < NUM_NEIGHBOURS; g++)
    begin : g_cell
        lmc_cell #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .clk    (clk),
            .load   (s1_ctl_reg.valid),
            .d      (nb_in[g]),
            .centre (centre_reg),
            .below  (nb_below[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_idx;
            s1_pixel_reg <= pixel_value;
        end
        if (s1_ctl_reg.valid)
        begin
            centre_reg <= ra_data[0];
        end
    end

    // ------------------------------------------------------------------------
    // Count and result buffer
    // ------------------------------------------------------------------------
    assign hit  = s2_ctl_reg.valid && s2_ctl_reg.test && (&nb_below);
    assign push = s2_ctl_reg.valid && s2_ctl_reg.last;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        total_next = total_reg;
        if (hit && (total_reg != '1))
        begin
            total_next = total_reg + COUNT_BITS'(1);
        end
    end

    // Frame ends still in the pipeline already own a buffer entry.
    assign pending = result_cnt_reg
                   + RESULT_CNT_BITS'(s1_ctl_reg.valid && s1_ctl_reg.last)
                   + RESULT_CNT_BITS'(s2_ctl_reg.valid && s2_ctl_reg.last);
    assign in_ready = (pending < RESULT_CNT_BITS'(RESULT_DEPTH));

    assign out_valid    = (result_cnt_reg != '0);
    assign minima_count = result_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            result_mem[wr_ptr_reg] <= total_next;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            column_reg      <= '0;
            row_reg         <= '0;
            total_reg       <= '0;
            s1_ctl_reg      <= '0;
            s2_ctl_reg      <= '0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            result_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                frame_width_reg <= cfg_write_data;
            end
            column_reg <= column_next;
            row_reg    <= row_next;

            s1_ctl_reg.valid <= accept;
            s1_ctl_reg.test  <= test_now;
            s1_ctl_reg.last  <= frame_end;
            s2_ctl_reg       <= s1_ctl_reg;

            if (push)
            begin
                total_reg  <= '0;
                wr_ptr_reg <= wr_ptr_reg + RESULT_PTR_BITS'(1);
            end
            else
            begin
                total_reg <= total_next;
            end

            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RESULT_PTR_BITS'(1);
            end

            if (push && !pop)
            begin
                result_cnt_reg <= result_cnt_reg + RESULT_CNT_BITS'(1);
            end
            else if (!push && pop)
            begin
                result_cnt_reg <= result_cnt_reg - RESULT_CNT_BITS'(1);
            end
        end
    end

endmodule

// ===== rtl/lmc_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line store
// One row of pixels: single write port, registered read ports, write-first.
// ----------------------------------------------------------------------------
module lmc_line_store #(
    parameter int DEPTH      = 1024,
    parameter int DATA_BITS  = 8,
    parameter int READ_PORTS = 1,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr [READ_PORTS],
    output logic [DATA_BITS-1:0] rd_data [READ_PORTS]
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read of the entry being written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < READ_PORTS; i++)
        begin
            if (rd_en)
            begin
                if (wr_en && (wr_addr == rd_addr[i]))
                begin
                    rd_data[i] <= wr_data;
                end
                else
                begin
                    rd_data[i] <= mem[rd_addr[i]];
                end
            end
        end
    end

endmodule

// ===== rtl/lmc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window cell
// Holds one neighbor pixel and flags when the center pixel lies below it.
// ----------------------------------------------------------------------------
module lmc_cell #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic [PIXEL_BITS-1:0] d,
    input  logic [PIXEL_BITS-1:0] centre,
    output logic                  below
);

    logic [PIXEL_BITS-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= d;
        end
    end

    assign below = (centre < value_reg);

endmodule
